FILE: src/security_assoc_spi_table_top_defines.svh
// ----------------------------------------------------------------------------
// security association table assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef SECURITY_ASSOC_SPI_TABLE_TOP_DEFINES_SVH
`define SECURITY_ASSOC_SPI_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// types and codes of the security association table
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

    localparam logic [1:0] KIND_UPSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_NEWEST = 2'd3;

    localparam logic [1:0] WIRE_VALID     = 2'd0;
    localparam logic [1:0] WIRE_MALFORMED = 2'd1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_UNSUP    = 3'd2;
    localparam logic [2:0] ST_STALE    = 3'd3;
    localparam logic [2:0] ST_CAPACITY = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic [31:0] HASH_MUL = 32'h7feb352d;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sa_spi;
        logic [63:0] ue_id;
        logic [31:0] pdu_id;
        logic [63:0] generation;
        logic [1:0]  wire_check;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [63:0] entry_generation;
        logic [6:0]  entry_count;
        logic [63:0] table_revision;
    } rsp_t;

    typedef struct packed {
        logic        used;
        logic [31:0] spi;
        logic [63:0] ue;
        logic [31:0] pdu;
        logic [63:0] install_gen;
        logic [63:0] watermark_gen;
    } entry_t;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_MUL   = 11'b00000000100,
        S_MOD   = 11'b00000001000,
        S_REM   = 11'b00000010000,
        S_PRD   = 11'b00000100000,
        S_PIDX  = 11'b00001000000,
        S_PENT  = 11'b00010000000,
        S_SCAN  = 11'b00100000000,
        S_SWEEP = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

endpackage

`default_nettype wire

FILE: src/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// sequencer: hash, index probe, entry scan and read-modify-write sweep
// ----------------------------------------------------------------------------
`default_nettype none
`include "security_assoc_spi_table_top_defines.svh"

module sat_ctrl import sat_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int INDEX_SLOTS = 128
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire req_t                                 req,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output rsp_t                                      rsp,
    output logic                                      idx_we,
    output logic [$clog2(INDEX_SLOTS)-1:0]            idx_waddr,
    output logic [$clog2(MAX_ENTRIES+2)-1:0]          idx_wdata,
    output logic [$clog2(INDEX_SLOTS)-1:0]            idx_raddr,
    input  wire logic [$clog2(MAX_ENTRIES+2)-1:0]     idx_rdata,
    output logic                                      ent_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]            ent_waddr,
    output entry_t                                    ent_wdata,
    output logic [$clog2(MAX_ENTRIES)-1:0]            ent_raddr,
    input  wire entry_t                               ent_rdata
);

    localparam int EW   = $clog2(MAX_ENTRIES);
    localparam int EC   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(INDEX_SLOTS);
    localparam int PC   = $clog2(INDEX_SLOTS + 1);
    localparam int VW   = $clog2(MAX_ENTRIES + 2);
    localparam int CLRN = (INDEX_SLOTS > MAX_ENTRIES) ? INDEX_SLOTS : MAX_ENTRIES;
    localparam int CW   = $clog2(CLRN);

    localparam logic [VW-1:0] MAXV = VW'(MAX_ENTRIES);
    localparam logic [VW-1:0] TOMB = VW'(MAX_ENTRIES + 1);

    // reciprocal of the index size, quotient estimate is low by at most one
    localparam logic [31:0] NSLOT32 = 32'(INDEX_SLOTS);
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(INDEX_SLOTS));

    state_t           state_reg, state_next;
    req_t             item_reg, item_next;
    logic [CW-1:0]    clr_reg, clr_next;
    logic [31:0]      hx_reg, hx_next;
    logic [31:0]      h_reg, h_next;
    logic [31:0]      q_reg, q_next;
    logic [31:0]      sum_reg, sum_next;
    logic [IW-1:0]    cell_reg, cell_next;
    logic [PC-1:0]    probe_reg, probe_next;
    logic [EW-1:0]    sel_reg, sel_next;
    logic             found_reg, found_next;
    logic [EW-1:0]    fent_reg, fent_next;
    logic [IW-1:0]    fcell_reg, fcell_next;
    logic             fsess_reg, fsess_next;
    logic [63:0]      finst_reg, finst_next;
    logic             tomb_reg, tomb_next;
    logic [IW-1:0]    tcell_reg, tcell_next;
    logic             empty_reg, empty_next;
    logic [IW-1:0]    ecell_reg, ecell_next;
    logic [EC-1:0]    acnt_reg, acnt_next;
    logic             rdv_reg, rdv_next;
    logic [EW-1:0]    rdi_reg, rdi_next;
    logic [63:0]      wm_reg, wm_next;
    logic             free_reg, free_next;
    logic [EW-1:0]    fidx_reg, fidx_next;
    logic             best_reg, best_next;
    logic [EW-1:0]    bidx_reg, bidx_next;
    logic [63:0]      binst_reg, binst_next;
    logic [EW-1:0]    target_reg, target_next;
    logic             fresh_reg, fresh_next;
    logic [2:0]       rst_reg, rst_next;
    logic [EW-1:0]    ridx_reg, ridx_next;
    logic [63:0]      rgen_reg, rgen_next;
    logic [EC-1:0]    used_reg, used_next;
    logic [63:0]      revision_reg, revision_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    always_comb
    begin
        logic [63:0]   prod;
        logic [63:0]   prodq;
        logic [31:0]   rem_v;
        logic          go_post;
        logic          go_scan;
        logic          go_fin;
        logic          go_decide;
        logic          advance;
        logic [2:0]    st_v;
        logic [EW-1:0] idx_v;
        logic [63:0]   gen_v;
        logic          sess;
        logic          last;
        logic [63:0]   wm_v;
        logic          free_v;
        logic [EW-1:0] fidx_v;
        logic          best_v;
        logic [EW-1:0] bidx_v;
        logic [63:0]   binst_v;
        logic [31:0]   sum_inc;
        entry_t        upd;

        state_next     = state_reg;
        item_next      = item_reg;
        clr_next       = clr_reg;
        hx_next        = hx_reg;
        h_next         = h_reg;
        q_next         = q_reg;
        sum_next       = sum_reg;
        cell_next      = cell_reg;
        probe_next     = probe_reg;
        sel_next       = sel_reg;
        found_next     = found_reg;
        fent_next      = fent_reg;
        fcell_next     = fcell_reg;
        fsess_next     = fsess_reg;
        finst_next     = finst_reg;
        tomb_next      = tomb_reg;
        tcell_next     = tcell_reg;
        empty_next     = empty_reg;
        ecell_next     = ecell_reg;
        acnt_next      = acnt_reg;
        rdv_next       = 1'b0;
        rdi_next       = rdi_reg;
        wm_next        = wm_reg;
        free_next      = free_reg;
        fidx_next      = fidx_reg;
        best_next      = best_reg;
        bidx_next      = bidx_reg;
        binst_next     = binst_reg;
        target_next    = target_reg;
        fresh_next     = fresh_reg;
        rst_next       = rst_reg;
        ridx_next      = ridx_reg;
        rgen_next      = rgen_reg;
        used_next      = used_reg;
        revision_next  = revision_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        idx_we    = 1'b0;
        idx_waddr = cell_reg;
        idx_wdata = '0;
        idx_raddr = cell_reg;
        ent_we    = 1'b0;
        ent_waddr = rdi_reg;
        ent_wdata = '0;
        ent_raddr = acnt_reg[EW-1:0];

        prod      = {32'b0, hx_reg} * {32'b0, HASH_MUL};
        prodq     = {32'b0, h_reg} * {32'b0, RECIP};
        rem_v     = '0;
        go_post   = 1'b0;
        go_scan   = 1'b0;
        go_fin    = 1'b0;
        go_decide = 1'b0;
        advance   = 1'b0;
        st_v      = ST_NOTFOUND;
        idx_v     = '0;
        gen_v     = '0;
        sess      = ent_rdata.used && (ent_rdata.ue == item_reg.ue_id)
                    && (ent_rdata.pdu == item_reg.pdu_id);
        last      = rdv_reg && (rdi_reg == EW'(MAX_ENTRIES - 1));
        wm_v      = wm_reg;
        free_v    = free_reg;
        fidx_v    = fidx_reg;
        best_v    = best_reg;
        bidx_v    = bidx_reg;
        binst_v   = binst_reg;
        sum_inc   = sum_reg + 32'd1;
        upd       = ent_rdata;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                idx_we    = (32'(clr_reg) < INDEX_SLOTS);
                idx_waddr = clr_reg[IW-1:0];
                ent_we    = (32'(clr_reg) < MAX_ENTRIES);
                ent_waddr = clr_reg[EW-1:0];
                clr_next  = clr_reg + CW'(1);
                if (clr_reg == CW'(CLRN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    hx_next    = req.sa_spi ^ (req.sa_spi >> 16);
                    found_next = 1'b0;
                    tomb_next  = 1'b0;
                    empty_next = 1'b0;
                    unique case (req.kind)
                        KIND_UPSERT:
                        begin
                            if (req.generation == 64'd0 || req.wire_check == WIRE_MALFORMED)
                            begin
                                st_v   = ST_BAD;
                                go_fin = 1'b1;
                            end
                            else if (req.wire_check != WIRE_VALID)
                            begin
                                st_v   = ST_UNSUP;
                                go_fin = 1'b1;
                            end
                            else if (req.sa_spi == 32'd0 || req.pdu_id == 32'd0)
                            begin
                                st_v   = ST_BAD;
                                go_fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (req.generation == 64'd0 || req.sa_spi == 32'd0)
                            begin
                                st_v   = ST_BAD;
                                go_fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (req.sa_spi == 32'd0)
                            begin
                                go_fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        KIND_NEWEST:
                        begin
                            if (req.pdu_id == 32'd0)
                            begin
                                go_fin = 1'b1;
                            end
                            else
                            begin
                                go_scan = 1'b1;
                            end
                        end
                        default:
                        begin
                            go_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                h_next     = prod[31:0] ^ (prod[31:0] >> 15);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                q_next     = prodq[63:32];
                state_next = S_REM;
            end
            S_REM:
            begin
                rem_v = h_reg - q_reg * NSLOT32;
                if (rem_v >= NSLOT32)
                begin
                    rem_v = rem_v - NSLOT32;
                end
                cell_next  = rem_v[IW-1:0];
                sum_next   = h_reg;
                probe_next = '0;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                state_next = S_PIDX;
            end
            S_PIDX:
            begin
                if (idx_rdata == '0)
                begin
                    empty_next = 1'b1;
                    ecell_next = cell_reg;
                    go_post    = 1'b1;
                end
                else if (idx_rdata > MAXV)
                begin
                    if (!tomb_reg)
                    begin
                        tomb_next  = 1'b1;
                        tcell_next = cell_reg;
                    end
                    advance = 1'b1;
                end
                else
                begin
                    ent_raddr  = EW'(idx_rdata - VW'(1));
                    sel_next   = EW'(idx_rdata - VW'(1));
                    state_next = S_PENT;
                end
            end
            S_PENT:
            begin
                if (ent_rdata.used && ent_rdata.spi == item_reg.sa_spi)
                begin
                    found_next = 1'b1;
                    fent_next  = sel_reg;
                    fcell_next = cell_reg;
                    fsess_next = (ent_rdata.ue == item_reg.ue_id)
                                 && (ent_rdata.pdu == item_reg.pdu_id);
                    finst_next = ent_rdata.install_gen;
                    go_post    = 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (32'(acnt_reg) < MAX_ENTRIES)
                begin
                    rdv_next  = 1'b1;
                    rdi_next  = acnt_reg[EW-1:0];
                    acnt_next = acnt_reg + EC'(1);
                end
                if (rdv_reg)
                begin
                    if (sess && ent_rdata.watermark_gen > wm_v)
                    begin
                        wm_v = ent_rdata.watermark_gen;
                    end
                    if (!ent_rdata.used && !free_v)
                    begin
                        free_v = 1'b1;
                        fidx_v = rdi_reg;
                    end
                    if (sess && (!best_v || ent_rdata.install_gen > binst_v))
                    begin
                        best_v  = 1'b1;
                        bidx_v  = rdi_reg;
                        binst_v = ent_rdata.install_gen;
                    end
                end
                wm_next    = wm_v;
                free_next  = free_v;
                fidx_next  = fidx_v;
                best_next  = best_v;
                bidx_next  = bidx_v;
                binst_next = binst_v;
                go_decide  = last;
            end
            S_SWEEP:
            begin
                if (32'(acnt_reg) < MAX_ENTRIES)
                begin
                    rdv_next  = 1'b1;
                    rdi_next  = acnt_reg[EW-1:0];
                    acnt_next = acnt_reg + EC'(1);
                end
                if (rdv_reg)
                begin
                    if (rdi_reg == target_reg)
                    begin
                        ent_we = 1'b1;
                        if (item_reg.kind == KIND_UPSERT)
                        begin
                            upd.used          = 1'b1;
                            upd.spi           = item_reg.sa_spi;
                            upd.ue            = item_reg.ue_id;
                            upd.pdu           = item_reg.pdu_id;
                            upd.install_gen   = item_reg.generation;
                            upd.watermark_gen = item_reg.generation;
                            ent_wdata         = upd;
                        end
                        else
                        begin
                            ent_wdata = '0;
                        end
                    end
                    else if (sess)
                    begin
                        ent_we            = 1'b1;
                        upd.watermark_gen = item_reg.generation;
                        ent_wdata         = upd;
                    end
                end
                if (last)
                begin
                    if (item_reg.kind == KIND_UPSERT)
                    begin
                        gen_v = item_reg.generation;
                        if (fresh_reg)
                        begin
                            used_next = used_reg + EC'(1);
                        end
                    end
                    else
                    begin
                        gen_v = finst_reg;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - EC'(1);
                        end
                    end
                    revision_next = revision_reg + 64'd1;
                    st_v          = ST_OK;
                    idx_v         = target_reg;
                    go_fin        = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next           = 1'b1;
                    out_next.status          = rst_reg;
                    out_next.slot            = 6'(ridx_reg);
                    out_next.entry_generation = rgen_reg;
                    out_next.entry_count     = 7'(used_reg);
                    out_next.table_revision  = revision_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (advance)
        begin
            if (probe_reg == PC'(INDEX_SLOTS - 1))
            begin
                go_post = 1'b1;
            end
            else
            begin
                probe_next = probe_reg + PC'(1);
                sum_next   = sum_inc;
                if (sum_inc == 32'd0 || cell_reg == IW'(INDEX_SLOTS - 1))
                begin
                    cell_next = '0;
                end
                else
                begin
                    cell_next = cell_reg + IW'(1);
                end
                state_next = S_PRD;
            end
        end

        if (go_post)
        begin
            unique case (item_reg.kind)
                KIND_LOOKUP:
                begin
                    if (found_next)
                    begin
                        st_v  = ST_OK;
                        idx_v = fent_next;
                        gen_v = finst_next;
                    end
                    go_fin = 1'b1;
                end
                KIND_UPSERT:
                begin
                    if (found_next && !fsess_next)
                    begin
                        st_v   = ST_BAD;
                        go_fin = 1'b1;
                    end
                    else
                    begin
                        go_scan = 1'b1;
                    end
                end
                KIND_DELETE:
                begin
                    if (!found_next || !fsess_next)
                    begin
                        go_fin = 1'b1;
                    end
                    else
                    begin
                        go_scan = 1'b1;
                    end
                end
                default:
                begin
                    go_fin = 1'b1;
                end
            endcase
        end

        if (go_decide)
        begin
            if (item_reg.kind == KIND_NEWEST)
            begin
                if (best_v)
                begin
                    st_v  = ST_OK;
                    idx_v = bidx_v;
                    gen_v = binst_v;
                end
                go_fin = 1'b1;
            end
            else if (item_reg.generation <= wm_v)
            begin
                st_v   = ST_STALE;
                go_fin = 1'b1;
            end
            else if (item_reg.kind == KIND_DELETE || found_reg)
            begin
                target_next = fent_reg;
                fresh_next  = 1'b0;
                if (item_reg.kind == KIND_DELETE)
                begin
                    idx_we    = 1'b1;
                    idx_waddr = fcell_reg;
                    idx_wdata = TOMB;
                end
                acnt_next  = '0;
                rdv_next   = 1'b0;
                state_next = S_SWEEP;
            end
            else if (!free_v || (!tomb_reg && !empty_reg))
            begin
                st_v   = ST_CAPACITY;
                go_fin = 1'b1;
            end
            else
            begin
                target_next = fidx_v;
                fresh_next  = 1'b1;
                idx_we      = 1'b1;
                idx_waddr   = tomb_reg ? tcell_reg : ecell_reg;
                idx_wdata   = VW'(fidx_v) + VW'(1);
                acnt_next   = '0;
                rdv_next    = 1'b0;
                state_next  = S_SWEEP;
            end
        end

        if (go_scan)
        begin
            acnt_next  = '0;
            rdv_next   = 1'b0;
            wm_next    = '0;
            free_next  = 1'b0;
            best_next  = 1'b0;
            binst_next = '0;
            state_next = S_SCAN;
        end

        if (go_fin)
        begin
            rst_next   = st_v;
            ridx_next  = (st_v == ST_OK) ? idx_v : '0;
            rgen_next  = (st_v == ST_OK) ? gen_v : '0;
            state_next = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            revision_reg  <= '0;
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
            acnt_reg      <= '0;
            probe_reg     <= '0;
            found_reg     <= 1'b0;
            tomb_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            free_reg      <= 1'b0;
            best_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            revision_reg  <= revision_next;
            out_valid_reg <= out_valid_next;
            rdv_reg       <= rdv_next;
            acnt_reg      <= acnt_next;
            probe_reg     <= probe_next;
            found_reg     <= found_next;
            tomb_reg      <= tomb_next;
            empty_reg     <= empty_next;
            free_reg      <= free_next;
            best_reg      <= best_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        hx_reg     <= hx_next;
        h_reg      <= h_next;
        q_reg      <= q_next;
        sum_reg    <= sum_next;
        cell_reg   <= cell_next;
        sel_reg    <= sel_next;
        fent_reg   <= fent_next;
        fcell_reg  <= fcell_next;
        fsess_reg  <= fsess_next;
        finst_reg  <= finst_next;
        tcell_reg  <= tcell_next;
        ecell_reg  <= ecell_next;
        rdi_reg    <= rdi_next;
        wm_reg     <= wm_next;
        fidx_reg   <= fidx_next;
        bidx_reg   <= bidx_next;
        binst_reg  <= binst_next;
        target_reg <= target_next;
        rst_reg    <= rst_next;
        ridx_reg   <= ridx_next;
        rgen_reg   <= rgen_next;
        out_reg    <= out_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `SAT_ASSERT_IMP(a_count_range, 1'b1, used_reg <= EC'(MAX_ENTRIES),
        "entry count above capacity")
    `SAT_ASSERT_IMP(a_fresh_room, state_reg == S_SWEEP && fresh_reg,
        used_reg < EC'(MAX_ENTRIES), "new entry with table full")
    `SAT_ASSERT_NEXT(a_rev_hold, state_reg != S_SWEEP,
        revision_reg == $past(revision_reg), "revision moved outside sweep")

endmodule

`default_nettype wire

FILE: src/security_assoc_spi_table_top.sv
// ----------------------------------------------------------------------------
// security_assoc_spi_table_top
// security association table keyed by inbound spi, hashed index with
// linear probing and tombstones, per-session generation watermarks
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  req_t
//  rsp      out  rsp_valid/rsp_stall  rsp_t
//
//  one item at a time; hash and index reduction go S_MUL, S_MOD, S_REM, each
//  index probe reads the index then, for a live slot, the entry, each entry
//  pass reads every entry in turn, then S_DONE loads the result register
//  upsert/delete: hash, probe, scan pass and write-back sweep pass
//  after reset a clearing pass over max(INDEX_SLOTS, MAX_ENTRIES) addresses runs
//  a held result does not block the next request transfer
// ----------------------------------------------------------------------------
`default_nettype none

module security_assoc_spi_table_top import sat_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int INDEX_SLOTS = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int IW = $clog2(INDEX_SLOTS);
    localparam int VW = $clog2(MAX_ENTRIES + 2);

    logic          idx_we;
    logic [IW-1:0] idx_waddr;
    logic [VW-1:0] idx_wdata;
    logic [IW-1:0] idx_raddr;
    logic [VW-1:0] idx_rdata;
    logic          ent_we;
    logic [EW-1:0] ent_waddr;
    entry_t        ent_wdata;
    logic [EW-1:0] ent_raddr;
    entry_t        ent_rdata;

    sat_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .INDEX_SLOTS(INDEX_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .idx_we    (idx_we),
        .idx_waddr (idx_waddr),
        .idx_wdata (idx_wdata),
        .idx_raddr (idx_raddr),
        .idx_rdata (idx_rdata),
        .ent_we    (ent_we),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata)
    );

    sat_ram #(
        .WIDTH(VW),
        .DEPTH(INDEX_SLOTS)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    sat_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

endmodule

`default_nettype wire
